### hw/rtl/etb_pkg.sv
// ----------------------------------------------------------------------------
// etb_pkg
// Shared widths, character codes and decode helpers for the escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package etb_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned OUT_COUNT_W = 16;
  localparam int unsigned LIMIT_W     = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

  localparam logic [BYTE_W-1:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CHAR_X         = 8'h78;

  typedef struct packed {
    logic [BYTE_W-1:0]      out_byte;
    logic                   byte_valid;
    logic                   string_done;
    logic [OUT_COUNT_W-1:0] out_count;
  } res_t;

  // Simple escapes; anything else maps to itself.
  function automatic logic [BYTE_W-1:0] simple_escape(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    unique case (c)
      8'h61:   r = 8'h07;  // a
      8'h62:   r = 8'h08;  // b
      8'h66:   r = 8'h0C;  // f
      8'h6E:   r = 8'h0A;  // n
      8'h72:   r = 8'h0D;  // r
      8'h74:   r = 8'h09;  // t
      8'h76:   r = 8'h0B;  // v
      8'h27:   r = 8'h27;
      8'h22:   r = 8'h22;
      8'h5C:   r = 8'h5C;
      8'h3F:   r = 8'h3F;
      default: r = c;
    endcase
    return r;
  endfunction

  // {is_hex, value}
  function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] d;
    logic [4:0]        r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      r = {1'b1, d[3:0]};
    end
    return r;
  endfunction

  function automatic logic is_octal(input logic [BYTE_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h37);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/etb_ifs.sv
// ----------------------------------------------------------------------------
// etb_ifs
// Valid/ready channels for text input and decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface etb_text_if import etb_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface etb_result_if import etb_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [BYTE_W-1:0]      out_byte;
  logic                   byte_valid;
  logic                   string_done;
  logic [OUT_COUNT_W-1:0] out_count;

  modport source (output valid, output out_byte, output byte_valid, output string_done,
                  output out_count, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input string_done,
                  input out_count, output ready);
endinterface

`default_nettype wire

### hw/rtl/escape_text_to_bytes.sv
// ----------------------------------------------------------------------------
// escape_text_to_bytes
// Streaming C escape-sequence decoder with a per-string output limit.
// ----------------------------------------------------------------------------
// One text byte is taken per cycle whenever the result queue holds two or
// fewer results. Each byte is decoded in the cycle it is accepted and yields
// zero, one or two results, which appear on the result channel from the next
// cycle on, one per cycle while the channel is ready. A byte that flushes a
// short hex or octal escape and is then decoded again, or an end of string
// that flushes a pending escape, can give two results; a long run of those is
// limited to one result per cycle by the result channel. output_limit may be
// written only while the block is idle.
`default_nettype none

module escape_text_to_bytes import etb_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  etb_text_if.sink            text,
  etb_result_if.source        result,
  input  logic                cfg_write_en,
  input  logic [LIMIT_W-1:0]  cfg_write_data
);

  localparam int unsigned CW     = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QN_W   = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_ESC,
    MODE_HEX0,
    MODE_HEX1,
    MODE_OCT1,
    MODE_OCT2
  } mode_t;

  mode_t                 mode, mode_next;
  logic [BYTE_W-1:0]     partial, partial_next;
  logic [COUNT_BITS-1:0] count, count_next;
  logic                  stopped, stopped_next;
  logic [LIMIT_W-1:0]    limit;

  res_t                  q [QDEPTH];
  res_t                  q_next [QDEPTH];
  logic [QN_W-1:0]       qn, qn_next;

  logic                  accept, pop;
  logic [BYTE_W-1:0]     c;
  logic                  is_end;
  logic [4:0]            hv;
  logic                  oct;
  logic [CW-1:0]         lim;
  logic                  at_lim, hit1, hit2;
  logic [COUNT_BITS-1:0] count1, count2;
  logic                  e1, e2, done, flush;
  logic [BYTE_W-1:0]     v1, v2;
  res_t                  r0, r1;
  logic                  push0, push1;
  logic [QN_W-1:0]       base;

  assign c      = text.in_byte;
  assign is_end = text.end_of_string || (c == '0);
  assign hv     = hex_digit(c);
  assign oct    = is_octal(c);

  assign lim    = (CW'(limit) < CW'({COUNT_BITS{1'b1}})) ? CW'(limit)
                                                         : CW'({COUNT_BITS{1'b1}});
  assign count1 = count + COUNT_BITS'(1);
  assign count2 = count + COUNT_BITS'(2);
  assign at_lim = stopped || (CW'(count) >= lim);
  assign hit1   = CW'(count1) >= lim;
  assign hit2   = CW'(count2) >= lim;

  always_comb begin
    mode_next    = mode;
    partial_next = partial;
    count_next   = count;
    stopped_next = stopped;
    e1    = 1'b0;
    e2    = 1'b0;
    v1    = '0;
    v2    = '0;
    done  = 1'b0;
    flush = 1'b0;
    if (is_end) begin
      done = 1'b1;
      if (!at_lim) begin
        unique case (mode)
          MODE_HEX0: begin
            e1 = 1'b1;
          end
          MODE_HEX1, MODE_OCT1, MODE_OCT2: begin
            e1 = 1'b1;
            v1 = partial;
          end
          default: ;
        endcase
      end
      mode_next    = MODE_NORMAL;
      partial_next = '0;
      count_next   = '0;
      stopped_next = 1'b0;
    end else if (at_lim) begin
      stopped_next = 1'b1;
      mode_next    = MODE_NORMAL;
    end else begin
      unique case (mode)
        MODE_ESC: begin
          if (c == CHAR_X) begin
            mode_next    = MODE_HEX0;
            partial_next = '0;
          end else if (oct) begin
            mode_next    = MODE_OCT1;
            partial_next = {5'd0, c[2:0]};
          end else begin
            mode_next = MODE_NORMAL;
            e1        = 1'b1;
            v1        = simple_escape(c);
          end
        end
        MODE_HEX0: begin
          if (hv[4]) begin
            mode_next    = MODE_HEX1;
            partial_next = {4'd0, hv[3:0]};
          end else begin
            mode_next = MODE_NORMAL;
            e1        = 1'b1;
            flush     = 1'b1;
          end
        end
        MODE_HEX1: begin
          mode_next = MODE_NORMAL;
          e1        = 1'b1;
          if (hv[4]) begin
            v1 = {partial[3:0], hv[3:0]};
          end else begin
            v1    = partial;
            flush = 1'b1;
          end
        end
        MODE_OCT1: begin
          if (oct) begin
            mode_next    = MODE_OCT2;
            partial_next = {partial[4:0], 3'd0} + {5'd0, c[2:0]};
          end else begin
            mode_next = MODE_NORMAL;
            e1        = 1'b1;
            v1        = partial;
            flush     = 1'b1;
          end
        end
        MODE_OCT2: begin
          mode_next = MODE_NORMAL;
          e1        = 1'b1;
          if (oct) begin
            v1 = {partial[4:0], 3'd0} + {5'd0, c[2:0]};
          end else begin
            v1    = partial;
            flush = 1'b1;
          end
        end
        default: begin
          mode_next = MODE_NORMAL;
          if (c == CHAR_BACKSLASH) begin
            mode_next = MODE_ESC;
          end else begin
            e1 = 1'b1;
            v1 = c;
          end
        end
      endcase
      if (e1) begin
        count_next = count1;
        if (hit1) begin
          stopped_next = 1'b1;
          mode_next    = MODE_NORMAL;
        end else if (flush) begin
          if (c == CHAR_BACKSLASH) begin
            mode_next = MODE_ESC;
          end else begin
            e2         = 1'b1;
            v2         = c;
            count_next = count2;
            if (hit2) begin
              stopped_next = 1'b1;
            end
          end
        end
      end
    end
  end

  // First result: emitted byte, else the closing result; second: flushed byte, else closing.
  always_comb begin
    if (e1) begin
      r0 = '{out_byte: v1, byte_valid: 1'b1, string_done: 1'b0,
             out_count: OUT_COUNT_W'(count1)};
    end else begin
      r0 = '{out_byte: '0, byte_valid: 1'b0, string_done: 1'b1,
             out_count: OUT_COUNT_W'(count)};
    end
    if (e2) begin
      r1 = '{out_byte: v2, byte_valid: 1'b1, string_done: 1'b0,
             out_count: OUT_COUNT_W'(count2)};
    end else begin
      r1 = '{out_byte: '0, byte_valid: 1'b0, string_done: 1'b1,
             out_count: OUT_COUNT_W'(count1)};
    end
  end

  assign text.ready = (qn <= QN_W'(QDEPTH - 2));
  assign accept     = text.valid && text.ready;
  assign pop        = result.valid && result.ready;
  assign push0      = accept && (e1 || done);
  assign push1      = accept && e1 && (e2 || done);
  assign base       = qn - QN_W'(pop);

  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_next[i] = q[i];
      if (pop && (i < QDEPTH - 1)) begin
        q_next[i] = q[(i + 1) % QDEPTH];
      end
      if (push0 && (QN_W'(i) == base)) begin
        q_next[i] = r0;
      end
      if (push1 && (QN_W'(i) == base + QN_W'(1))) begin
        q_next[i] = r1;
      end
    end
    qn_next = base + QN_W'(push0) + QN_W'(push1);
  end

  assign result.valid       = (qn != '0);
  assign result.out_byte    = q[0].out_byte;
  assign result.byte_valid  = q[0].byte_valid;
  assign result.string_done = q[0].string_done;
  assign result.out_count   = q[0].out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_NORMAL;
      partial <= '0;
      count   <= '0;
      stopped <= 1'b0;
      limit   <= LIMIT_RESET;
      qn      <= '0;
    end else begin
      if (accept) begin
        mode    <= mode_next;
        partial <= partial_next;
        count   <= count_next;
        stopped <= stopped_next;
      end
      if (cfg_write_en) begin
        limit <= cfg_write_data;
      end
      qn <= qn_next;
    end
    q <= q_next;
  end

endmodule

`default_nettype wire

### hw/rtl/etb_checker.sv
// ----------------------------------------------------------------------------
// etb_checker
// Port-level checks on the result channel of the escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module etb_checker import etb_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [BYTE_W-1:0]      out_byte,
  input logic                   byte_valid,
  input logic                   string_done,
  input logic [OUT_COUNT_W-1:0] out_count
);

  // closing transaction never carries a byte
  a_done_no_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_done |-> !byte_valid)
    else $error("closing transaction carries a byte");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> out_byte == '0)
    else $error("empty transaction has nonzero byte");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_count)
      && $stable(byte_valid) && $stable(string_done))
    else $error("stalled result changed");

endmodule

bind escape_text_to_bytes etb_checker u_etb_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_byte    (result.out_byte),
  .byte_valid  (result.byte_valid),
  .string_done (result.string_done),
  .out_count   (result.out_count)
);

`default_nettype wire

### bench/escape_text_to_bytes_test.sv
// ----------------------------------------------------------------------------
// escape_text_to_bytes_test
// Self-checking bench for the streaming escape decoder. A short table of text
// covers plain bytes, simple, hex and octal escapes, flushes at the end of a
// string and a lone trailing backslash. Random strings follow under several
// output limits and with gaps on both channels. Each result transaction is
// compared with the table's expected result or with a bit-accurate decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_text_to_bytes_test import etb_pkg::*;;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PHASES         = 6;

  localparam int unsigned PHASE_LIMIT [PHASES] = '{65535, 3, 0, 1, 0, 65535};
  localparam int          PHASE_ITEMS [PHASES] = '{350, 250, 60, 150, 250, 300};
  localparam int          PHASE_GAP   [PHASES] = '{0, 88, 0, 8, 8, 0};
  localparam int          PHASE_STALL [PHASES] = '{0, 0, 88, 8, 8, 0};

  typedef enum logic [2:0] {
    TXT_PLAIN, TXT_ESC, TXT_HEX0, TXT_HEX1, TXT_OCT1, TXT_OCT2
  } decode_mode_t;

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              eos;
    logic              typed;
    res_t              want;
  } text_row_t;

  // byte, end, typed, then {out_byte, byte_valid, string_done, out_count}
  text_row_t text_rows [24] = '{
    {8'h41, 1'b0, 1'b1, 8'h41, 1'b1, 1'b0, 16'd1},
    {8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, 16'd2},
    {8'h5C, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
    {8'h6E, 1'b0, 1'b1, 8'h0A, 1'b1, 1'b0, 16'd3},
    {8'h5C, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
    {8'h78, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
    {8'h46, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
    {8'h66, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, 16'd4},
    {8'h5C, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
    {8'h37, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
    {8'h37, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
    {8'h37, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, 16'd5},
    {8'h5C, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
    {8'h78, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
    {8'h47, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
    {8'h5C, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
    {8'h31, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
    {8'h32, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
    {8'h5C, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
    {8'h5C, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
    {8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 16'd0},
    {8'h5C, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
    {8'h78, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0},
    {8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                cfg_write_en;
  logic [LIMIT_W-1:0]  cfg_write_data;

  etb_text_if   txt_ch ();
  etb_result_if res_ch ();

  escape_text_to_bytes dut (
    .clk            (clk),
    .rst            (rst),
    .text           (txt_ch),
    .result         (res_ch),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  always #5 clk = ~clk;

  // decoder state
  decode_mode_t          dec_mode    = TXT_PLAIN;
  logic [BYTE_W-1:0]     dec_partial = '0;
  logic [OUT_COUNT_W-1:0] dec_count  = '0;
  logic                  dec_stopped = 1'b0;
  logic [LIMIT_W-1:0]    limit_now   = LIMIT_RESET;

  res_t decoded_step [$];
  res_t expected_q [$];

  int send_gap_pct    = 0;
  int stall_pct       = 0;
  int quiet_cycles    = 0;
  int errors          = 0;
  int items_sent      = 0;
  int phase_items     = 0;
  int strings_sent    = 0;
  int results_checked = 0;

  function automatic int hex_value(input logic [BYTE_W-1:0] ch);
    if (ch >= "0" && ch <= "9") return int'(ch - "0");
    if (ch >= "A" && ch <= "F") return int'(ch - "A") + 10;
    if (ch >= "a" && ch <= "f") return int'(ch - "a") + 10;
    return -1;
  endfunction

  function automatic bit octal_digit(input logic [BYTE_W-1:0] ch);
    return ch >= "0" && ch <= "7";
  endfunction

  function automatic logic [BYTE_W-1:0] escape_code(input logic [BYTE_W-1:0] ch);
    case (ch)
      "a":     return 8'h07;
      "b":     return 8'h08;
      "f":     return 8'h0C;
      "n":     return 8'h0A;
      "r":     return 8'h0D;
      "t":     return 8'h09;
      "v":     return 8'h0B;
      default: return ch;  // quote, double quote, backslash, ? and others map to themselves
    endcase
  endfunction

  function automatic bit limit_hit();
    return dec_stopped || dec_count >= limit_now;
  endfunction

  function automatic void record(input logic [BYTE_W-1:0] b, input logic v, input logic d);
    decoded_step.push_back({b, v, d, dec_count});
  endfunction

  // returns 0 once the limit stops the string
  function automatic bit emit_byte(input logic [BYTE_W-1:0] b);
    dec_count = dec_count + 1'b1;
    record(b, 1'b1, 1'b0);
    if (limit_hit()) begin
      dec_stopped = 1'b1;
      dec_mode = TXT_PLAIN;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void plain_char(input logic [BYTE_W-1:0] ch);
    if (ch == CHAR_BACKSLASH) begin
      dec_mode = TXT_ESC;
    end else begin
      void'(emit_byte(ch));
    end
  endfunction

  // returns 0 when the byte is dropped past the limit
  function automatic bit decode_text(input logic [BYTE_W-1:0] ch, input logic eos);
    int hv;
    hv = hex_value(ch);
    if (eos || ch == 8'h00) begin
      if (!limit_hit()) begin
        if (dec_mode == TXT_HEX0) begin
          void'(emit_byte(8'h00));
        end else if (dec_mode inside {TXT_HEX1, TXT_OCT1, TXT_OCT2}) begin
          void'(emit_byte(dec_partial));
        end
      end
      record(8'h00, 1'b0, 1'b1);
      dec_mode = TXT_PLAIN;
      dec_partial = '0;
      dec_count = '0;
      dec_stopped = 1'b0;
      return 1'b1;
    end
    if (limit_hit()) begin
      dec_stopped = 1'b1;
      dec_mode = TXT_PLAIN;
      return 1'b0;
    end
    case (dec_mode)
      TXT_ESC: begin
        dec_mode = TXT_PLAIN;
        if (ch == CHAR_X) begin
          dec_mode = TXT_HEX0;
          dec_partial = '0;
        end else if (octal_digit(ch)) begin
          dec_mode = TXT_OCT1;
          dec_partial = {5'd0, ch[2:0]};
        end else begin
          void'(emit_byte(escape_code(ch)));
        end
      end
      TXT_HEX0: begin
        if (hv >= 0) begin
          dec_mode = TXT_HEX1;
          dec_partial = 8'(hv);
        end else begin
          dec_mode = TXT_PLAIN;
          if (emit_byte(8'h00)) plain_char(ch);
        end
      end
      TXT_HEX1: begin
        dec_mode = TXT_PLAIN;
        if (hv >= 0) begin
          void'(emit_byte({dec_partial[3:0], 4'(hv)}));
        end else if (emit_byte(dec_partial)) begin
          plain_char(ch);
        end
      end
      TXT_OCT1: begin
        if (octal_digit(ch)) begin
          dec_mode = TXT_OCT2;
          dec_partial = {dec_partial[4:0], ch[2:0]};
        end else begin
          dec_mode = TXT_PLAIN;
          if (emit_byte(dec_partial)) plain_char(ch);
        end
      end
      TXT_OCT2: begin
        dec_mode = TXT_PLAIN;
        if (octal_digit(ch)) begin
          void'(emit_byte({dec_partial[4:0], ch[2:0]}));
        end else if (emit_byte(dec_partial)) begin
          plain_char(ch);
        end
      end
      default: begin
        dec_mode = TXT_PLAIN;
        plain_char(ch);
      end
    endcase
    return 1'b1;
  endfunction

  task automatic send_item(input logic [BYTE_W-1:0] ch, input logic eos, input logic typed,
                           input res_t want);
    if ($urandom_range(99) < send_gap_pct) begin
      txt_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    txt_ch.valid <= 1'b1;
    txt_ch.in_byte <= ch;
    txt_ch.end_of_string <= eos;
    do @(posedge clk); while (!txt_ch.ready);
    decoded_step.delete();
    void'(decode_text(ch, eos));
    if (typed) begin
      expected_q.push_back(want);
    end else begin
      foreach (decoded_step[i]) expected_q.push_back(decoded_step[i]);
    end
    items_sent++;
    phase_items++;
    if (eos || ch == 8'h00) strings_sent++;
  endtask

  task automatic send_char(input logic [BYTE_W-1:0] ch);
    send_item(ch, 1'b0, 1'b0, '0);
  endtask

  task automatic send_string(input int min_tokens, input int max_tokens, input bit close_it);
    string escapes;
    string hex_digits;
    int kind;
    logic [BYTE_W-1:0] c;
    escapes = "abfnrtv'\"\\?";
    hex_digits = "0123456789abcdefABCDEF";
    repeat ($urandom_range(max_tokens, min_tokens)) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        do c = 8'($urandom_range(1, 255)); while (c == CHAR_BACKSLASH);
        send_char(c);
      end else if (kind < 45) begin
        send_char(CHAR_BACKSLASH);
        send_char(escapes[$urandom_range(10)]);
      end else if (kind < 50) begin
        send_char(CHAR_BACKSLASH);
        send_char(8'($urandom_range(1, 255)));
      end else if (kind < 68) begin
        send_char(CHAR_BACKSLASH);
        send_char(CHAR_X);
        repeat ($urandom_range(2)) send_char(hex_digits[$urandom_range(21)]);
      end else if (kind < 86) begin
        send_char(CHAR_BACKSLASH);
        repeat ($urandom_range(1, 3)) send_char(8'h30 + 8'($urandom_range(7)));
      end else if (kind < 93) begin
        send_char(CHAR_BACKSLASH);
      end else begin
        send_char(8'($urandom_range(255)));
      end
    end
    if (close_it) begin
      if ($urandom_range(1) == 1) begin
        send_item(8'($urandom_range(255)), 1'b1, 1'b0, '0);
      end else begin
        send_char(8'h00);
      end
    end
  endtask

  task automatic drain();
    txt_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_sink
    res_t seen;
    res_t want;
    seen = {res_ch.out_byte, res_ch.byte_valid, res_ch.string_done, res_ch.out_count};
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        results_checked++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction byte=%02h valid=%0b done=%0b count=%0d",
                   $time, seen.out_byte, seen.byte_valid, seen.string_done,
                   seen.out_count);
        end else begin
          want = expected_q.pop_front();
          if (seen !== want) begin
            errors++;
            $display("%0t: expected byte=%02h valid=%0b done=%0b count=%0d, %s",
                     $time, want.out_byte, want.byte_valid, want.string_done,
                     want.out_count,
                     $sformatf("got byte=%02h valid=%0b done=%0b count=%0d",
                               seen.out_byte, seen.byte_valid, seen.string_done,
                               seen.out_count));
          end
        end
      end
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
    if ((txt_ch.valid && txt_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("** escape_text_to_bytes: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [LIMIT_W-1:0] lim;
    int strings_in_phase;
    txt_ch.valid <= 1'b0;
    txt_ch.in_byte <= '0;
    txt_ch.end_of_string <= 1'b0;
    cfg_write_en <= 1'b0;
    cfg_write_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (text_rows[i])
      send_item(text_rows[i].ch, text_rows[i].eos, text_rows[i].typed, text_rows[i].want);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      lim = LIMIT_W'(PHASE_LIMIT[p]);
      if (p == 4) lim = LIMIT_W'($urandom_range(5, 20));
      send_gap_pct = PHASE_GAP[p];
      stall_pct = PHASE_STALL[p];
      cfg_write_en <= 1'b1;
      cfg_write_data <= lim;
      @(posedge clk);
      cfg_write_en <= 1'b0;
      limit_now = lim;

      phase_items = 0;
      strings_in_phase = 0;
      while (phase_items < PHASE_ITEMS[p]) begin
        if (p == 0 && strings_in_phase == 0) send_string(150, 200, 1'b1);
        else send_string(0, 12, 1'b1);
        strings_in_phase++;
      end
      // leave a string open so the next limit lands mid-string
      if (p < PHASES - 1) send_string(1, 3, 1'b0);
      drain();
    end

    $display("Decoded %0d text transactions in %0d strings under six output limits,",
             items_sent, strings_sent);
    $display("checked %0d results with sender gaps and receiver stalls of 0, 8 and 88%%.",
             results_checked);
    if (errors == 0) begin
      $display("** escape_text_to_bytes: PASSED **");
    end else begin
      $display("** escape_text_to_bytes: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
